// ----- src/hsv2rgb_pkg.sv -----
// Shared types, constants and helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

  // Register stages from input to output register
  localparam int unsigned NSTG = 7;

  // Hue arithmetic
  localparam int unsigned DEG_FULL   = 360;
  localparam int unsigned DEG_SEXT   = 60;
  localparam int unsigned FULL_SCALE = 255;

  // Biased hue: (hue + 32768) + HUE_BIAS is a positive multiple-of-360 shift
  localparam logic [16:0] HUE_BIAS  = 17'd352;
  // floor(x/360) estimate as (x * HUE_RECIP) >> HUE_SHIFT, low by at most one
  localparam logic [12:0] HUE_RECIP = 13'd5825;
  localparam int unsigned HUE_SHIFT = 21;

  // Sextant of the hue circle, which sets the channel order
  typedef enum logic [2:0] {
    SX_RED_YEL = 3'd0,
    SX_YEL_GRN = 3'd1,
    SX_GRN_CYN = 3'd2,
    SX_CYN_BLU = 3'd3,
    SX_BLU_MAG = 3'd4,
    SX_MAG_RED = 3'd5
  } sext_t;

  // Exact floor(x/255) for x up to 255*255 (any product of two bytes)
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // Clamp a signed 16-bit value to 0..255
  function automatic logic [7:0] clip255(input logic signed [15:0] x);
    logic [7:0] res;
    if (x[15]) begin
      res = 8'd0;
    end else if (x[14:8] != 7'd0) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

endpackage

// ----- src/hsv2rgb_if.sv -----
// Valid/ready stream interfaces for HSV requests and RGB results.
interface hsv2rgb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic signed [15:0] saturation;
  logic signed [15:0] level;

  modport source (output valid, output hue, output saturation, output level, input ready);
  modport sink   (input valid, input hue, input saturation, input level, output ready);
endinterface

interface hsv2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- src/hsv_to_rgb_converter_top.sv -----
// HSV to RGB converter: seven-stage pipeline from request to registered result.
// Throughput: one request per cycle while the output takes results; each stage
// holds one request and moves on when the stage after it is empty or moving,
// so bubbles are squeezed out.
// Reset (rst, synchronous) clears all stage valid bits; payload is not reset.
// The block keeps no state between requests.
module hsv_to_rgb_converter_top (
  input  logic          clk,
  input  logic          rst,
  hsv2rgb_in_if.sink    pix_in,
  hsv2rgb_out_if.source pix_out
);
  import hsv2rgb_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // Stage 1: biased hue and quotient estimate, clamped S and L
  logic [16:0] s1_x;
  logic [7:0]  s1_q;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_lev;
  // Stage 2: hue wrapped to 0..359
  logic [8:0]  s2_hd;
  logic [7:0]  s2_sat;
  logic [7:0]  s2_lev;
  // Stage 3: sextant and scaled fraction
  sext_t       s3_sx;
  logic [7:0]  s3_frac;
  logic [7:0]  s3_sat;
  logic [7:0]  s3_lev;
  // Stage 4: first products
  sext_t       s4_sx;
  logic [15:0] s4_pfall;
  logic [15:0] s4_prise;
  logic [15:0] s4_plo;
  logic [7:0]  s4_lev;
  // Stage 5: shade factors and low value
  sext_t       s5_sx;
  logic [7:0]  s5_kfall;
  logic [7:0]  s5_krise;
  logic [7:0]  s5_lo;
  logic [7:0]  s5_lev;
  // Stage 6: level times shade factors
  sext_t       s6_sx;
  logic [15:0] s6_pfall;
  logic [15:0] s6_prise;
  logic [7:0]  s6_lo;
  logic [7:0]  s6_lev;
  // Stage 7: output register
  logic [7:0]  s7_red;
  logic [7:0]  s7_green;
  logic [7:0]  s7_blue;

  // Stall chain: a stage loads when empty or when the next stage loads
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || pix_out.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_in.ready = en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1 logic
  logic [16:0] h_bias;
  logic [29:0] q_prod;
  always_comb begin
    h_bias = {1'b0, ~pix_in.hue[15], pix_in.hue[14:0]} + HUE_BIAS;
    q_prod = 30'(h_bias) * 30'(HUE_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_x   <= h_bias;
      s1_q   <= q_prod[HUE_SHIFT+7:HUE_SHIFT];
      s1_sat <= clip255(pix_in.saturation);
      s1_lev <= clip255(pix_in.level);
    end
  end

  // Stage 2 logic: remainder with one correction step
  logic [16:0] rem_full;
  logic [9:0]  rem;
  logic [9:0]  rem_adj;
  always_comb begin
    rem_full = s1_x - 17'(s1_q * 17'(DEG_FULL));
    rem      = rem_full[9:0];
    rem_adj  = rem - 10'(DEG_FULL);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_hd  <= (rem >= 10'(DEG_FULL)) ? rem_adj[8:0] : rem[8:0];
      s2_sat <= s1_sat;
      s2_lev <= s1_lev;
    end
  end

  // Stage 3 logic: sextant by compare, fraction = offset * 255 / 60 = offset * 17 / 4
  sext_t      sx;
  logic [8:0] sx_base;
  logic [5:0] offs;
  logic [9:0] offs17;
  always_comb begin
    priority if (s2_hd >= 9'(5 * DEG_SEXT)) begin
      sx = SX_MAG_RED;
      sx_base = 9'(5 * DEG_SEXT);
    end else if (s2_hd >= 9'(4 * DEG_SEXT)) begin
      sx = SX_BLU_MAG;
      sx_base = 9'(4 * DEG_SEXT);
    end else if (s2_hd >= 9'(3 * DEG_SEXT)) begin
      sx = SX_CYN_BLU;
      sx_base = 9'(3 * DEG_SEXT);
    end else if (s2_hd >= 9'(2 * DEG_SEXT)) begin
      sx = SX_GRN_CYN;
      sx_base = 9'(2 * DEG_SEXT);
    end else if (s2_hd >= 9'(DEG_SEXT)) begin
      sx = SX_YEL_GRN;
      sx_base = 9'(DEG_SEXT);
    end else begin
      sx = SX_RED_YEL;
      sx_base = 9'd0;
    end
    offs   = 6'(s2_hd - sx_base);
    offs17 = {offs, 4'd0} + {4'd0, offs};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_sx   <= sx;
      s3_frac <= offs17[9:2];
      s3_sat  <= s2_sat;
      s3_lev  <= s2_lev;
    end
  end

  // Stage 4 logic: saturation and level products
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_sx    <= s3_sx;
      s4_pfall <= 16'(s3_sat) * 16'(s3_frac);
      s4_prise <= 16'(s3_sat) * 16'(8'(FULL_SCALE) - s3_frac);
      s4_plo   <= 16'(s3_lev) * 16'(8'(FULL_SCALE) - s3_sat);
      s4_lev   <= s3_lev;
    end
  end

  // Stage 5 logic: divide by 255 and complement
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_sx    <= s4_sx;
      s5_kfall <= 8'(FULL_SCALE) - div255(s4_pfall);
      s5_krise <= 8'(FULL_SCALE) - div255(s4_prise);
      s5_lo    <= div255(s4_plo);
      s5_lev   <= s4_lev;
    end
  end

  // Stage 6 logic: level times shade factors
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_sx    <= s5_sx;
      s6_pfall <= 16'(s5_lev) * 16'(s5_kfall);
      s6_prise <= 16'(s5_lev) * 16'(s5_krise);
      s6_lo    <= s5_lo;
      s6_lev   <= s5_lev;
    end
  end

  // Stage 7 logic: final divide and channel order
  logic [7:0] fall;
  logic [7:0] rise;
  logic [7:0] r_nx;
  logic [7:0] g_nx;
  logic [7:0] b_nx;
  always_comb begin
    fall = div255(s6_pfall);
    rise = div255(s6_prise);
    unique case (s6_sx)
      SX_RED_YEL: begin r_nx = s6_lev; g_nx = rise;   b_nx = s6_lo;  end
      SX_YEL_GRN: begin r_nx = fall;   g_nx = s6_lev; b_nx = s6_lo;  end
      SX_GRN_CYN: begin r_nx = s6_lo;  g_nx = s6_lev; b_nx = rise;   end
      SX_CYN_BLU: begin r_nx = s6_lo;  g_nx = fall;   b_nx = s6_lev; end
      SX_BLU_MAG: begin r_nx = rise;   g_nx = s6_lo;  b_nx = s6_lev; end
      default:    begin r_nx = s6_lev; g_nx = s6_lo;  b_nx = fall;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_red   <= r_nx;
      s7_green <= g_nx;
      s7_blue  <= b_nx;
    end
  end

  assign pix_out.valid = vld[NSTG-1];
  assign pix_out.red   = s7_red;
  assign pix_out.green = s7_green;
  assign pix_out.blue  = s7_blue;

endmodule

// ----- src/hsv2rgb_chk.sv -----
// Port-level checker for the HSV to RGB converter, bound to the top level.
module hsv2rgb_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // A stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("result dropped or changed while stalled");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Requests are refused only while a finished result waits
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without back-pressure");

  // A pipeline depth with no request and no result means it is empty
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !(in_valid && in_ready)) [*7] |=> !out_valid)
    else $error("result without a request");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_chk u_hsv2rgb_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red       (pix_out.red),
  .green     (pix_out.green),
  .blue      (pix_out.blue)
);
